// ===== hw/rtl/hms_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hms_pkg: shared types and helpers of the hybrid merge sort block
// Holds the controller state encoding, the element width and the order test.
// ----------------------------------------------------------------------------
package hms_pkg;

  localparam int unsigned VAL_W = 32;

  typedef logic signed [VAL_W-1:0] val_t;

  // One-hot controller states.
  typedef enum logic [13:0] {
    ST_LOAD      = 14'b00000000000001,
    ST_INS_RUN   = 14'b00000000000010,
    ST_INS_NEXT  = 14'b00000000000100,
    ST_INS_KEY   = 14'b00000000001000,
    ST_INS_CMP   = 14'b00000000010000,
    ST_INS_PUT   = 14'b00000000100000,
    ST_MRG_SETUP = 14'b00000001000000,
    ST_MRG_LA    = 14'b00000010000000,
    ST_MRG_LB    = 14'b00000100000000,
    ST_MRG_CMP   = 14'b00001000000000,
    ST_MRG_COPY  = 14'b00010000000000,
    ST_MRG_DRAIN = 14'b00100000000000,
    ST_OUT_RD    = 14'b01000000000000,
    ST_OUT_PUT   = 14'b10000000000000
  } state_t;

  // True when a has to leave the block before b in the selected order.
  function automatic logic goes_before(input val_t a, input val_t b, input logic desc);
    goes_before = desc ? (a > b) : (a < b);
  endfunction

endpackage

// ===== hw/rtl/hybrid_merge_sort.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hybrid_merge_sort: memory based sorter for sets of signed 32-bit values
// Collects a set, sorts it with insertion sorted runs and bottom-up merging,
// then streams the set out in ascending or descending order.
// ----------------------------------------------------------------------------
// Usage. Values arrive as requests on the in_ stream, one value per request;
// the request with in_tlast high closes the set. Up to DEPTH values are kept;
// later ones in the same set are dropped and every result of that set then
// carries out_tuser (overflow) high. After the closing request in_tready
// drops, the block sorts the element store in place and sends the set on the
// out_ stream, out_tlast marking the final result. The cfg_ channel writes
// the descending bit (reset value 1, largest first); write it only between
// sets. While loading, in_tready stays high, so every offered request is
// taken. Sorting first orders each run of SMALL_RUN entries by insertion,
// shifting entries up one position at a time; each merge pass then writes
// the merged pair of runs into scratch, one compare and scratch write per
// entry, and copies it back, all paced by the single read port of the
// element store. Each result is read from the store, then registered on the
// output. A stalled receiver simply holds the output register and pauses
// the sequencer. The result register is separate from the input side, so
// the next set may start loading while the last result still waits.
// Reset (rst_n low, synchronous) empties the set and clears overflow; the
// memories need no clearing since only entries written in a set are read.
// ----------------------------------------------------------------------------
module hybrid_merge_sort
  import hms_pkg::*;
#(
  parameter int unsigned DEPTH     = 64,
  parameter int unsigned SMALL_RUN = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  // Input stream
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [VAL_W-1:0] in_tdata,   // [31:0] value
  input  logic             in_tlast,   // is_last
  // Result stream
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [VAL_W-1:0] out_tdata,  // [31:0] value_res
  output logic             out_tlast,  // is_last_res
  output logic             out_tuser,  // [0] overflow
  // Configuration write channel
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic             cfg_data    // descending
);

  // Address, count and arithmetic widths. SW leaves room for lo + 2*width.
  localparam int unsigned AW  = $clog2(DEPTH);
  localparam int unsigned CW  = $clog2(DEPTH + 1);
  localparam int unsigned RW  = $clog2(SMALL_RUN + 1);
  localparam int unsigned SW  = ((CW > RW) ? CW : RW) + 3;

  state_t          state_r, state_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;       // number of values held
  logic            ovf_r, ovf_nxt;       // values were dropped in this set
  logic            desc_r;

  logic [SW-1:0]   lo_r, lo_nxt;         // start of the current run or pair
  logic [SW-1:0]   wid_r, wid_nxt;       // current merge run width
  logic [CW-1:0]   hi_r, hi_nxt;
  logic [CW-1:0]   mid_r, mid_nxt;
  logic [CW-1:0]   i_r, i_nxt;
  logic [CW-1:0]   j_r, j_nxt;
  logic [CW-1:0]   a_r, a_nxt;
  logic [CW-1:0]   b_r, b_nxt;
  logic [CW-1:0]   k_r, k_nxt;
  val_t            key_r, key_nxt;
  val_t            head_a_r, head_a_nxt;
  val_t            head_b_r, head_b_nxt;
  logic            fwd_a_r, fwd_a_nxt;   // head of side a comes from read data
  logic            fwd_b_r, fwd_b_nxt;
  logic            cp_v_r, cp_v_nxt;     // copy pipeline holds a read
  logic [CW-1:0]   cp_idx_r, cp_idx_nxt;

  logic            out_v_r, out_v_nxt;
  val_t            out_d_r, out_d_nxt;
  logic            out_l_r, out_l_nxt;
  logic            out_o_r, out_o_nxt;

  // Memory ports.
  logic            st_we;
  logic [AW-1:0]   st_waddr;
  val_t            st_wdata;
  logic [AW-1:0]   st_raddr;
  logic [VAL_W-1:0] st_rdata;
  logic            sc_we;
  logic [AW-1:0]   sc_waddr;
  val_t            sc_wdata;
  logic [AW-1:0]   sc_raddr;
  logic [VAL_W-1:0] sc_rdata;

  // Helper values.
  logic [SW-1:0]   n_ext;
  logic [SW-1:0]   lo_run_end;
  logic [SW-1:0]   lo_mid;
  logic [SW-1:0]   lo_pair_end;
  val_t            rd_val;
  val_t            eff_a;
  val_t            eff_b;
  logic            take_a;
  logic            in_acc;
  logic            out_free;

  hms_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  hms_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_scratch (
    .clk   (clk),
    .we    (sc_we),
    .waddr (sc_waddr),
    .wdata (sc_wdata),
    .raddr (sc_raddr),
    .rdata (sc_rdata)
  );

  assign in_tready  = (state_r == ST_LOAD);
  assign in_acc     = in_tvalid && in_tready;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_v_r;
  assign out_tdata  = out_d_r;
  assign out_tlast  = out_l_r;
  assign out_tuser  = out_o_r;
  assign out_free   = !out_v_r || out_tready;

  assign n_ext       = SW'(cnt_r);
  assign lo_run_end  = lo_r + SW'(SMALL_RUN);
  assign lo_mid      = lo_r + wid_r;
  assign lo_pair_end = lo_r + {wid_r[SW-2:0], 1'b0};
  assign rd_val      = val_t'(st_rdata);

  // Merge heads: the side consumed last cycle takes the fresh read data.
  assign eff_a  = fwd_a_r ? rd_val : head_a_r;
  assign eff_b  = fwd_b_r ? rd_val : head_b_r;
  // Ties take side a, which keeps the merge equal to a plain sort.
  assign take_a = (b_r >= hi_r) ||
                  ((a_r < mid_r) && !goes_before(eff_b, eff_a, desc_r));

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    ovf_nxt    = ovf_r;
    lo_nxt     = lo_r;
    wid_nxt    = wid_r;
    hi_nxt     = hi_r;
    mid_nxt    = mid_r;
    i_nxt      = i_r;
    j_nxt      = j_r;
    a_nxt      = a_r;
    b_nxt      = b_r;
    k_nxt      = k_r;
    key_nxt    = key_r;
    head_a_nxt = head_a_r;
    head_b_nxt = head_b_r;
    fwd_a_nxt  = fwd_a_r;
    fwd_b_nxt  = fwd_b_r;
    cp_v_nxt   = 1'b0;
    cp_idx_nxt = cp_idx_r;
    out_v_nxt  = out_v_r && !out_tready;
    out_d_nxt  = out_d_r;
    out_l_nxt  = out_l_r;
    out_o_nxt  = out_o_r;

    st_we    = 1'b0;
    st_waddr = cnt_r[AW-1:0];
    st_wdata = val_t'(in_tdata);
    st_raddr = k_r[AW-1:0];
    sc_we    = 1'b0;
    sc_waddr = k_r[AW-1:0];
    sc_wdata = take_a ? eff_a : eff_b;
    sc_raddr = k_r[AW-1:0];

    case (state_r)
      ST_LOAD: begin
        if (in_acc) begin
          if (cnt_r < CW'(DEPTH)) begin
            st_we   = 1'b1;
            cnt_nxt = CW'(cnt_r + 1'b1);
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_tlast) begin
            lo_nxt    = '0;
            state_nxt = ST_INS_RUN;
          end
        end
      end

      // Insertion sort of the run starting at lo.
      ST_INS_RUN: begin
        if (lo_r < n_ext) begin
          hi_nxt    = (lo_run_end < n_ext) ? CW'(lo_run_end) : cnt_r;
          i_nxt     = CW'(lo_r + 1'b1);
          state_nxt = ST_INS_NEXT;
        end else begin
          lo_nxt    = '0;
          wid_nxt   = SW'(SMALL_RUN);
          state_nxt = ST_MRG_SETUP;
        end
      end

      ST_INS_NEXT: begin
        st_raddr = i_r[AW-1:0];
        if (i_r < hi_r) begin
          state_nxt = ST_INS_KEY;
        end else begin
          lo_nxt    = lo_run_end;
          state_nxt = ST_INS_RUN;
        end
      end

      ST_INS_KEY: begin
        key_nxt   = rd_val;
        j_nxt     = i_r;
        st_raddr  = AW'(i_r - 1'b1);
        state_nxt = ST_INS_CMP;
      end

      // Read data holds entry j-1; shift it up while the key goes first.
      ST_INS_CMP: begin
        st_we    = 1'b1;
        st_waddr = j_r[AW-1:0];
        st_raddr = AW'(j_r - 2'd2);
        if (goes_before(key_r, rd_val, desc_r)) begin
          st_wdata = rd_val;
          j_nxt    = CW'(j_r - 1'b1);
          if (SW'(CW'(j_r - 1'b1)) > lo_r) begin
            state_nxt = ST_INS_CMP;
          end else begin
            state_nxt = ST_INS_PUT;
          end
        end else begin
          st_wdata  = key_r;
          i_nxt     = CW'(i_r + 1'b1);
          state_nxt = ST_INS_NEXT;
        end
      end

      ST_INS_PUT: begin
        st_we     = 1'b1;
        st_waddr  = j_r[AW-1:0];
        st_wdata  = key_r;
        i_nxt     = CW'(i_r + 1'b1);
        state_nxt = ST_INS_NEXT;
      end

      // Bottom-up merge: pick the next pair of runs or double the width.
      ST_MRG_SETUP: begin
        st_raddr = lo_r[AW-1:0];
        if (wid_r >= n_ext) begin
          k_nxt     = '0;
          state_nxt = ST_OUT_RD;
        end else if ((lo_r >= n_ext) || (lo_mid >= n_ext)) begin
          wid_nxt = {wid_r[SW-2:0], 1'b0};
          lo_nxt  = '0;
        end else begin
          mid_nxt   = CW'(lo_mid);
          hi_nxt    = (lo_pair_end < n_ext) ? CW'(lo_pair_end) : cnt_r;
          a_nxt     = CW'(lo_r);
          b_nxt     = CW'(lo_mid);
          k_nxt     = CW'(lo_r);
          state_nxt = ST_MRG_LA;
        end
      end

      ST_MRG_LA: begin
        head_a_nxt = rd_val;
        st_raddr   = b_r[AW-1:0];
        state_nxt  = ST_MRG_LB;
      end

      ST_MRG_LB: begin
        head_b_nxt = rd_val;
        fwd_a_nxt  = 1'b0;
        fwd_b_nxt  = 1'b0;
        state_nxt  = ST_MRG_CMP;
      end

      // One element a cycle into scratch; the winner's side is refetched.
      ST_MRG_CMP: begin
        sc_we      = 1'b1;
        head_a_nxt = eff_a;
        head_b_nxt = eff_b;
        fwd_a_nxt  = take_a;
        fwd_b_nxt  = !take_a;
        if (take_a) begin
          a_nxt    = CW'(a_r + 1'b1);
          st_raddr = AW'(a_r + 1'b1);
        end else begin
          b_nxt    = CW'(b_r + 1'b1);
          st_raddr = AW'(b_r + 1'b1);
        end
        if (CW'(k_r + 1'b1) == hi_r) begin
          k_nxt     = CW'(lo_r);
          state_nxt = ST_MRG_COPY;
        end else begin
          k_nxt = CW'(k_r + 1'b1);
        end
      end

      // Scratch back to the store; each entry is written in the cycle after its read.
      ST_MRG_COPY: begin
        st_we      = cp_v_r;
        st_waddr   = cp_idx_r[AW-1:0];
        st_wdata   = val_t'(sc_rdata);
        cp_v_nxt   = 1'b1;
        cp_idx_nxt = k_r;
        k_nxt      = CW'(k_r + 1'b1);
        if (CW'(k_r + 1'b1) == hi_r) begin
          state_nxt = ST_MRG_DRAIN;
        end
      end

      ST_MRG_DRAIN: begin
        st_we     = 1'b1;
        st_waddr  = cp_idx_r[AW-1:0];
        st_wdata  = val_t'(sc_rdata);
        lo_nxt    = lo_pair_end;
        state_nxt = ST_MRG_SETUP;
      end

      ST_OUT_RD: begin
        state_nxt = ST_OUT_PUT;
      end

      ST_OUT_PUT: begin
        if (out_free) begin
          out_v_nxt = 1'b1;
          out_d_nxt = rd_val;
          out_o_nxt = ovf_r;
          out_l_nxt = (CW'(k_r + 1'b1) == cnt_r);
          if (CW'(k_r + 1'b1) == cnt_r) begin
            cnt_nxt   = '0;
            ovf_nxt   = 1'b0;
            state_nxt = ST_LOAD;
          end else begin
            k_nxt     = CW'(k_r + 1'b1);
            state_nxt = ST_OUT_RD;
          end
        end
      end

      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      cnt_r   <= '0;
      ovf_r   <= 1'b0;
      desc_r  <= 1'b1;
      out_v_r <= 1'b0;
      cp_v_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      ovf_r   <= ovf_nxt;
      out_v_r <= out_v_nxt;
      cp_v_r  <= cp_v_nxt;
      if (cfg_valid && cfg_ready) begin
        desc_r <= cfg_data;
      end
    end
  end

  // Indexes and data registers.
  always_ff @(posedge clk) begin
    lo_r     <= lo_nxt;
    wid_r    <= wid_nxt;
    hi_r     <= hi_nxt;
    mid_r    <= mid_nxt;
    i_r      <= i_nxt;
    j_r      <= j_nxt;
    a_r      <= a_nxt;
    b_r      <= b_nxt;
    k_r      <= k_nxt;
    key_r    <= key_nxt;
    head_a_r <= head_a_nxt;
    head_b_r <= head_b_nxt;
    fwd_a_r  <= fwd_a_nxt;
    fwd_b_r  <= fwd_b_nxt;
    cp_idx_r <= cp_idx_nxt;
    out_d_r  <= out_d_nxt;
    out_l_r  <= out_l_nxt;
    out_o_r  <= out_o_nxt;
  end

  // The fill count never passes the store depth.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH))
    else $error("fill count exceeds store depth");

  // A merge step always writes inside the current pair.
  a_merge_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MRG_CMP) |-> ((k_r < hi_r) && (SW'(k_r) >= lo_r)))
    else $error("merge write outside the pair");

  // The insertion shift never moves below the start of its run.
  a_ins_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_INS_CMP) |-> ((SW'(j_r) > lo_r) && (j_r < hi_r)))
    else $error("insertion shift outside the run");

  // After the final result of a set the block is back to loading, empty.
  a_set_done: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_OUT_PUT) && out_free && (CW'(k_r + 1'b1) == cnt_r))
      |=> ((state_r == ST_LOAD) && (cnt_r == '0) && out_tlast && out_tvalid))
    else $error("set did not close cleanly");

endmodule

// ===== hw/rtl/hms_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hms_ram: generic single-write, single-read synchronous RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module hms_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== test/tb_hybrid_merge_sort.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_hybrid_merge_sort: self-checking testbench of the hybrid merge sorter
// Streams sets of signed values into the sorter and keeps its own sorted copy
// of every set. Each result is checked for its value, its last marker and its
// overflow flag. Directed sets cover the value extremes, duplicates and both
// orders. Random sets follow, some of them beyond the store depth. Both
// streams stall at random, and in every fifth random phase the receiver holds off once for a long time.
// ----------------------------------------------------------------------------
module tb_hybrid_merge_sort;
  import hms_pkg::*;

  localparam int unsigned SET_DEPTH   = 64;
  localparam int unsigned RUN_LEN     = 16;
  localparam int unsigned RAND_ITEMS  = 200;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned SETTLE      = 20;
  localparam int unsigned PRINT_LIMIT = 20;

  typedef struct {
    val_t value;
    logic last;
  } load_item_t;

  typedef struct {
    val_t value;
    logic last;
    logic overflow;
  } sorted_res_t;

  logic             clk        = 1'b0;
  logic             rst_n      = 1'b0;
  logic             in_tvalid  = 1'b0;
  logic             in_tready;
  logic [VAL_W-1:0] in_tdata   = '0;
  logic             in_tlast   = 1'b0;
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [VAL_W-1:0] out_tdata;
  logic             out_tlast;
  logic             out_tuser;
  logic             cfg_valid  = 1'b0;
  logic             cfg_ready;
  logic             cfg_data   = 1'b0;

  // Requests still to be sent, and results still to come.
  load_item_t  load_q[$];
  sorted_res_t sorted_q[$];

  // Own copy of the sorter: the set being collected and the order bit.
  val_t        set_buf[SET_DEPTH];
  int unsigned set_cnt    = 0;
  logic        set_ovf    = 1'b0;
  logic        order_desc = 1'b1;

  int unsigned mismatch_cnt = 0;
  int unsigned tx_gap       = 0;
  int unsigned rx_gap       = 0;
  int unsigned rx_hold      = 0;
  int unsigned hold_req     = 0;
  int unsigned hold_ack     = 0;
  int unsigned rand_items   = 0;
  int unsigned phase        = 0;
  int unsigned set_len      = 0;
  int unsigned n_sets       = 0;
  bit          tx_idle_en   = 1'b1;
  bit          rx_idle_en   = 1'b1;
  val_t        prev_value   = '0;
  load_item_t  next_item;
  sorted_res_t exp_res;

  hybrid_merge_sort #(
    .DEPTH     (SET_DEPTH),
    .SMALL_RUN (RUN_LEN)
  ) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always #5 clk = ~clk;

  task automatic report_mismatch(input string msg);
    if (mismatch_cnt < PRINT_LIMIT) begin
      $display("ERROR at %0t: %s", $time, msg);
    end
    mismatch_cnt++;
  endtask

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end else if (r < 85) begin
      return $urandom_range(1, 3);
    end else if (r < 97) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(25, 60);
  endfunction

  // Adds one accepted request to the set. The request that closes the set sorts
  // it and queues every result of the set in the selected order.
  function automatic void collect_value(input val_t v, input logic last);
    int unsigned i;
    int unsigned j;
    val_t        key;
    sorted_res_t r;
    if (set_cnt < SET_DEPTH) begin
      set_buf[set_cnt] = v;
      set_cnt++;
    end else begin
      set_ovf = 1'b1;
    end
    if (last) begin
      for (i = 1; i < set_cnt; i++) begin
        key = set_buf[i];
        j   = i;
        while (j > 0 && (order_desc ? (key > set_buf[j-1]) : (key < set_buf[j-1]))) begin
          set_buf[j] = set_buf[j-1];
          j--;
        end
        set_buf[j] = key;
      end
      for (i = 0; i < set_cnt; i++) begin
        r.value    = set_buf[i];
        r.last     = (i + 1 == set_cnt);
        r.overflow = set_ovf;
        sorted_q   = {sorted_q, r};
      end
      set_cnt = 0;
      set_ovf = 1'b0;
    end
  endfunction

  // Random element: full range, small values near zero, extremes and repeats.
  function automatic val_t rand_value();
    val_t v;
    case ($urandom_range(0, 5))
      0, 1, 2: v = $urandom;
      3:       v = $signed($urandom_range(0, 20)) - 10;
      4: begin
        case ($urandom_range(0, 4))
          0:       v = 32'sh8000_0000;
          1:       v = 32'sh7FFF_FFFF;
          2:       v = '0;
          3:       v = -1;
          default: v = 1;
        endcase
      end
      default: v = prev_value;
    endcase
    prev_value = v;
    return v;
  endfunction

  task automatic queue_value(input val_t v, input logic last);
    load_item_t it;
    it.value = v;
    it.last  = last;
    load_q   = {load_q, it};
  endtask

  task automatic queue_set(input int unsigned len);
    int unsigned i;
    for (i = 0; i < len; i++) begin
      queue_value(rand_value(), i + 1 == len);
    end
  endtask

  // Waits until every request is taken and every result has come, then lets
  // the sorter settle back into its load state.
  task automatic wait_drained();
    while (load_q.size() != 0 || in_tvalid || sorted_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE) @(posedge clk);
  endtask

  // Writes the order bit; only called while the sorter is idle.
  task automatic write_order(input logic desc);
    @(posedge clk);
    cfg_data  <= desc;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid  <= 1'b0;
    order_desc  = desc;
  endtask

  // Driver: offers the queued requests, with random gaps between them when tx_idle_en is set.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
      in_tlast  <= 1'b0;
      tx_gap     = 0;
    end else begin
      if (in_tvalid && in_tready) begin
        collect_value(in_tdata, in_tlast);
      end
      if (in_tvalid && !in_tready) begin
        // The request stays on the bus until it is taken.
      end else if (tx_gap != 0) begin
        tx_gap--;
        in_tvalid <= 1'b0;
      end else if (load_q.size() != 0) begin
        next_item = load_q.pop_front();
        in_tdata  <= next_item.value;
        in_tlast  <= next_item.last;
        in_tvalid <= 1'b1;
        if (tx_idle_en) begin
          tx_gap = pick_gap();
        end
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Monitor: checks each result against the oldest expectation and stalls the
  // result stream at random. An armed hold starts with the first valid result.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      rx_gap      = 0;
      rx_hold     = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (sorted_q.size() == 0) begin
          report_mismatch($sformatf("result %h arrived with nothing expected", out_tdata));
        end else begin
          exp_res = sorted_q.pop_front();
          if (out_tdata !== exp_res.value) begin
            report_mismatch($sformatf("value %h, expected %h", out_tdata, exp_res.value));
          end
          if (out_tlast !== exp_res.last) begin
            report_mismatch($sformatf("last marker %b, expected %b", out_tlast,
                                      exp_res.last));
          end
          if (out_tuser !== exp_res.overflow) begin
            report_mismatch($sformatf("overflow flag %b, expected %b", out_tuser,
                                      exp_res.overflow));
          end
        end
      end
      if (hold_req != hold_ack) begin
        out_tready <= 1'b0;
        if (out_tvalid) begin
          hold_ack = hold_req;
          rx_hold  = HOLD_CYCLES;
        end
      end else if (rx_hold != 0) begin
        rx_hold--;
        out_tready <= 1'b0;
      end else if (rx_gap != 0) begin
        rx_gap--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        if (rx_idle_en && $urandom_range(0, 2) == 0) begin
          rx_gap = pick_gap();
        end
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed sets, first with the order bit at its reset value (largest first).
    queue_value(32'sh8000_0000, 1'b1);
    queue_value(32'sh0000_0000, 1'b0);
    queue_value(32'sh7FFF_FFFF, 1'b0);
    queue_value(32'sh8000_0000, 1'b0);
    queue_value(32'shFFFF_FFFF, 1'b0);
    queue_value(32'sh0000_0001, 1'b0);
    queue_value(32'sh8000_0000, 1'b1);
    wait_drained();

    write_order(1'b0);
    queue_value(32'sh7FFF_FFFF, 1'b0);
    queue_value(32'sh8000_0001, 1'b0);
    queue_value(32'sh5555_5555, 1'b0);
    queue_value(32'shAAAA_AAAA, 1'b0);
    queue_value(32'sh7FFF_FFFF, 1'b0);
    queue_value(32'sh0000_0000, 1'b0);
    queue_value(32'sh1234_5678, 1'b1);
    queue_value(-3, 1'b0);
    queue_value(3, 1'b1);
    wait_drained();

    write_order(1'b1);
    queue_value(32'shAAAA_AAAA, 1'b0);
    queue_value(32'sh5555_5555, 1'b0);
    queue_value(5, 1'b0);
    queue_value(-5, 1'b0);
    queue_value(5, 1'b0);
    queue_value(5, 1'b1);
    wait_drained();

    // Random phases. Each phase picks an order and an idling mode and sends a
    // few sets, most of them short; a handful of sets reach or pass the store
    // depth, and in those that pass it the closing request itself is dropped.
    while (rand_items < RAND_ITEMS) begin
      write_order(1'($urandom_range(0, 1)));
      tx_idle_en = (phase % 4 != 1);
      rx_idle_en = (phase % 4 != 2);
      if (phase % 5 == 0) begin
        // The receiver stalls long while the sender keeps offering sets.
        tx_idle_en = 1'b0;
        hold_req++;
      end
      n_sets = $urandom_range(2, 5);
      for (int unsigned s = 0; s < n_sets; s++) begin
        if (phase == 1 && s == 0) begin
          set_len = SET_DEPTH + 1;
        end else if (phase == 2 && s == 0) begin
          set_len = SET_DEPTH;
        end else if (phase == 4 && s == 0) begin
          set_len = SET_DEPTH + 4;
        end else begin
          case ($urandom_range(0, 39))
            0:             set_len = SET_DEPTH;
            1:             set_len = SET_DEPTH + 1;
            2:             set_len = $urandom_range(SET_DEPTH + 2, SET_DEPTH + 6);
            3, 4, 5, 6, 7, 8, 9:
                           set_len = $urandom_range(RUN_LEN + 1, 3 * RUN_LEN);
            default:       set_len = $urandom_range(1, RUN_LEN);
          endcase
        end
        queue_set(set_len);
        rand_items += set_len;
      end
      wait_drained();
      phase++;
    end

    repeat (50) @(posedge clk);
    if (mismatch_cnt == 0 && sorted_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Watchdog far beyond the slowest correct run.
  initial begin
    #10_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
